[rtl/core/bes_pkg.sv]
// Shared types and constants of the block extent set table.
`default_nettype none

package bes_pkg;

	// Default number of extent entries held in the table.
	localparam int MAX_EXTENTS_DEF = 16;

	// Request codes.
	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_TRUNC  = 3'd2;
	localparam logic [2:0] REQ_QUERY  = 3'd3;
	localparam logic [2:0] REQ_COUNT  = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EXISTS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	// One table entry: first block and block count.
	typedef struct packed {
		logic [31:0] start;
		logic [32:0] len;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

[rtl/core/bes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/block_extent_set_table_core.sv]
// Top level of the block extent set table: sequencer around the extent RAM.
// An empty-table or unknown request shows its result in the cycle after acceptance.
// Otherwise busy covers a scan of the entries from entry 0, a merge check, a read,
// the entries moved and a write for an insert or split. One transaction at a time.
// Reset clears the state, the done strobe and the entry count, so the table is empty with no clearing pass.
`default_nettype none

module block_extent_set_table_core #(
	parameter int MAX_EXTENTS = bes_pkg::MAX_EXTENTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] block_index,
	input  wire logic [31:0] new_size,
	output logic             done,
	output logic [1:0]       status,
	output logic             present,
	output logic [32:0]      block_total
);

	localparam int AW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_MERGE = 6'b000100,
		S_MV_RD = 6'b001000,
		S_MV_WR = 6'b010000,
		S_PUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [2:0]  type_q, type_d;
	logic [31:0] blk_q, blk_d;
	logic [31:0] ns_q, ns_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] cut_pos_q, cut_pos_d;
	logic cut_found_q, cut_found_d;
	logic [32:0] total_q, total_d;
	bes_pkg::entry_t merge_q, merge_d;
	bes_pkg::entry_t new_q, new_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [AW-1:0] mv_src_q, mv_src_d;
	logic [AW-1:0] mv_last_q, mv_last_d;
	logic mv_up_q, mv_up_d;
	logic done_q, done_d;
	logic [1:0] status_q, status_d;
	logic present_q, present_d;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	bes_pkg::entry_t ram_wdata, rd;
	logic [bes_pkg::ENTRY_W-1:0] ram_rdata;

	bes_ram #(
		.WIDTH(bes_pkg::ENTRY_W),
		.DEPTH(MAX_EXTENTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd = bes_pkg::entry_t'(ram_rdata);

	// Values of the entry just read and of the request.
	logic [32:0] rs, rend, blk33, blk_p1, ns33;
	logic last, full;
	logic [AW-1:0] idx_p1;
	logic [CW-1:0] used_m1;

	assign rs      = {1'b0, rd.start};
	assign rend    = rs + rd.len;
	assign blk33   = {1'b0, blk_q};
	assign blk_p1  = blk33 + 33'd1;
	assign ns33    = {1'b0, ns_q};
	assign used_m1 = used_q - CW'(1);
	assign last    = (CW'(idx_q) == used_m1);
	assign full    = (used_q == CW'(MAX_EXTENTS));
	assign idx_p1  = idx_q + AW'(1);

	// Sequencer: scan, read-modify-write of entries, and shifts.
	always_comb begin
		state_d     = state_q;
		type_d      = type_q;
		blk_d       = blk_q;
		ns_d        = ns_q;
		idx_d       = idx_q;
		used_d      = used_q;
		cut_pos_d   = cut_pos_q;
		cut_found_d = cut_found_q;
		total_d     = total_q;
		merge_d     = merge_q;
		new_d       = new_q;
		pos_d       = pos_q;
		mv_src_d    = mv_src_q;
		mv_last_d   = mv_last_q;
		mv_up_d     = mv_up_q;
		done_d      = 1'b0;
		status_d    = status_q;
		present_d   = present_q;
		ram_we      = 1'b0;
		ram_waddr   = idx_q;
		ram_wdata   = '0;
		ram_raddr   = idx_p1;

		case (state_q)
			S_IDLE: begin
				ram_raddr = '0;
				if (start) begin
					type_d      = req_type;
					blk_d       = block_index;
					ns_d        = new_size;
					idx_d       = '0;
					total_d     = '0;
					status_d    = bes_pkg::ST_OK;
					present_d   = 1'b0;
					cut_found_d = 1'b0;
					if (req_type inside {bes_pkg::REQ_ADD, bes_pkg::REQ_REMOVE,
						bes_pkg::REQ_TRUNC, bes_pkg::REQ_QUERY, bes_pkg::REQ_COUNT} &&
						used_q != '0) begin
						state_d = S_SCAN;
					end else begin
						// Empty table or unknown request ends at once.
						done_d = 1'b1;
						if (req_type == bes_pkg::REQ_ADD) begin
							ram_we    = 1'b1;
							ram_waddr = '0;
							ram_wdata = '{start: block_index, len: 33'd1};
							used_d    = CW'(1);
						end else if (req_type == bes_pkg::REQ_REMOVE) begin
							status_d = bes_pkg::ST_ABSENT;
						end
					end
				end
			end

			S_SCAN: begin
				case (type_q)
					bes_pkg::REQ_ADD: begin
						if (rend == blk33) begin
							// Grow at the end, then check the next entry for a merge.
							ram_we    = 1'b1;
							ram_wdata = '{start: rd.start, len: rd.len + 33'd1};
							merge_d   = '{start: rd.start, len: rd.len + 33'd1};
							if (last) begin
								done_d  = 1'b1;
								state_d = S_IDLE;
							end else begin
								state_d = S_MERGE;
							end
						end else if (rs == blk_p1) begin
							ram_we    = 1'b1;
							ram_wdata = '{start: rd.start - 32'd1, len: rd.len + 33'd1};
							done_d    = 1'b1;
							state_d   = S_IDLE;
						end else if (rs <= blk33 && blk33 < rend) begin
							status_d = bes_pkg::ST_EXISTS;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else if (rs > blk33) begin
							if (full) begin
								status_d = bes_pkg::ST_FULL;
								done_d   = 1'b1;
								state_d  = S_IDLE;
							end else begin
								new_d     = '{start: blk_q, len: 33'd1};
								pos_d     = idx_q;
								mv_src_d  = used_m1[AW-1:0];
								mv_last_d = idx_q;
								mv_up_d   = 1'b1;
								state_d   = S_MV_RD;
							end
						end else if (last) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
							if (full) begin
								status_d = bes_pkg::ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = used_q[AW-1:0];
								ram_wdata = '{start: blk_q, len: 33'd1};
								used_d    = used_q + CW'(1);
							end
						end else begin
							idx_d = idx_p1;
						end
					end

					bes_pkg::REQ_REMOVE: begin
						if (rs == blk33) begin
							if (rd.len == 33'd1) begin
								// The extent empties and is dropped.
								if (last) begin
									used_d  = used_m1;
									done_d  = 1'b1;
									state_d = S_IDLE;
								end else begin
									mv_src_d  = idx_p1;
									mv_last_d = used_m1[AW-1:0];
									mv_up_d   = 1'b0;
									state_d   = S_MV_RD;
								end
							end else begin
								ram_we    = 1'b1;
								ram_wdata = '{start: rd.start + 32'd1, len: rd.len - 33'd1};
								done_d    = 1'b1;
								state_d   = S_IDLE;
							end
						end else if (rend == blk_p1) begin
							ram_we    = 1'b1;
							ram_wdata = '{start: rd.start, len: rd.len - 33'd1};
							done_d    = 1'b1;
							state_d   = S_IDLE;
						end else if (rs <= blk33 && blk33 < rend) begin
							if (full) begin
								status_d = bes_pkg::ST_FULL;
								done_d   = 1'b1;
								state_d  = S_IDLE;
							end else begin
								// Split: keep the low part here, insert the high part after.
								ram_we    = 1'b1;
								ram_wdata = '{start: rd.start, len: blk33 - rs};
								new_d     = '{start: blk_q + 32'd1, len: rend - blk_p1};
								pos_d     = idx_p1;
								if (last) begin
									state_d = S_PUT;
								end else begin
									mv_src_d  = used_m1[AW-1:0];
									mv_last_d = idx_p1;
									mv_up_d   = 1'b1;
									state_d   = S_MV_RD;
								end
							end
						end else if (last) begin
							status_d = bes_pkg::ST_ABSENT;
							done_d   = 1'b1;
							state_d  = S_IDLE;
						end else begin
							idx_d = idx_p1;
						end
					end

					bes_pkg::REQ_TRUNC: begin
						// Entries from the first one at or past the size are dropped; one that straddles the size is cut.
						if (rs >= ns33) begin
							total_d = total_q + rd.len;
							if (!cut_found_q) begin
								cut_found_d = 1'b1;
								cut_pos_d   = CW'(idx_q);
							end
						end else if (rend > ns33) begin
							total_d   = total_q + (rend - ns33);
							ram_we    = 1'b1;
							ram_wdata = '{start: rd.start, len: ns33 - rs};
						end
						if (last) begin
							if (cut_found_d) begin
								used_d = cut_pos_d;
							end
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							idx_d = idx_p1;
						end
					end

					bes_pkg::REQ_QUERY: begin
						if (rs <= blk33 && blk33 < rend) begin
							present_d = 1'b1;
							done_d    = 1'b1;
							state_d   = S_IDLE;
						end else if (last) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							idx_d = idx_p1;
						end
					end

					bes_pkg::REQ_COUNT: begin
						total_d = total_q + rd.len;
						if (last) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							idx_d = idx_p1;
						end
					end

					default: begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end

			S_MERGE: begin
				// The read data is the entry after the grown one.
				if (merge_q.start + merge_q.len == rs) begin
					ram_we    = 1'b1;
					ram_wdata = '{start: merge_q.start, len: merge_q.len + rd.len};
					if (CW'(idx_p1) == used_m1) begin
						used_d  = used_m1;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						mv_src_d  = idx_q + AW'(2);
						mv_last_d = used_m1[AW-1:0];
						mv_up_d   = 1'b0;
						state_d   = S_MV_RD;
					end
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end

			S_MV_RD: begin
				ram_raddr = mv_src_q;
				state_d   = S_MV_WR;
			end

			S_MV_WR: begin
				// Move one entry per cycle while the next source is read.
				ram_we    = 1'b1;
				ram_waddr = mv_up_q ? mv_src_q + AW'(1) : mv_src_q - AW'(1);
				ram_wdata = rd;
				if (mv_src_q == mv_last_q) begin
					if (mv_up_q) begin
						state_d = S_PUT;
					end else begin
						used_d  = used_m1;
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					mv_src_d  = mv_up_q ? mv_src_q - AW'(1) : mv_src_q + AW'(1);
					ram_raddr = mv_src_d;
				end
			end

			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = new_q;
				used_d    = used_q + CW'(1);
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			done_q  <= done_d;
		end
	end

	// Request and result registers.
	always_ff @(posedge clk) begin
		type_q      <= type_d;
		blk_q       <= blk_d;
		ns_q        <= ns_d;
		idx_q       <= idx_d;
		cut_pos_q   <= cut_pos_d;
		cut_found_q <= cut_found_d;
		total_q     <= total_d;
		merge_q     <= merge_d;
		new_q       <= new_d;
		pos_q       <= pos_d;
		mv_src_q    <= mv_src_d;
		mv_last_q   <= mv_last_d;
		mv_up_q     <= mv_up_d;
		status_q    <= status_d;
		present_q   <= present_d;
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign present     = present_q;
	assign block_total = total_q;

	// The entry count never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_EXTENTS))
		else $error("extent count exceeds table depth");

	// The sequencer is always in exactly one state.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");

	// A result is shown only once the sequencer is back to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy)
		else $error("result strobe while busy");

	// An accepted transaction either finishes at once or keeps the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q))
		else $error("accepted transaction lost");

	// The RAM is written only while a transaction is in progress or being taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (busy || start))
		else $error("RAM write with no transaction");

endmodule

`default_nettype wire
